### sv/http_response_body_deframer_assert.svh
// assertion macros for the http response body deframer
// used by the top level only, no other dependencies
`ifndef HTTP_RESPONSE_BODY_DEFRAMER_ASSERT_SVH
`define HTTP_RESPONSE_BODY_DEFRAMER_ASSERT_SVH

// implication checked on every clock edge outside reset
`define HRBD_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication checked outside reset
`define HRBD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### sv/hrbd_pkg.sv
// shared types and constants for the http response body deframer
// no dependencies
package hrbd_pkg;

   localparam logic [1:0] ACT_START = 2'd0;
   localparam logic [1:0] ACT_BYTE  = 2'd1;
   localparam logic [1:0] ACT_DISC  = 2'd2;
   localparam logic [1:0] ACT_TICK  = 2'd3;

   localparam logic [2:0] PH_IDLE   = 3'd0;
   localparam logic [2:0] PH_HEADER = 3'd1;
   localparam logic [2:0] PH_LBODY  = 3'd2;
   localparam logic [2:0] PH_CSIZE  = 3'd3;
   localparam logic [2:0] PH_CDATA  = 3'd4;
   localparam logic [2:0] PH_CCRLF  = 3'd5;
   localparam logic [2:0] PH_DONE   = 3'd6;

   localparam logic [2:0] ERR_NONE   = 3'd0;
   localparam logic [2:0] ERR_SOCKET = 3'd1;
   localparam logic [2:0] ERR_CLIENT = 3'd2;
   localparam logic [2:0] ERR_SERVER = 3'd3;
   localparam logic [2:0] ERR_TIMEOUT = 3'd4;

   localparam logic [4:0] TE_LEN = 5'd17;
   localparam logic [4:0] CL_LEN = 5'd14;

   // byte classification done in the front part
   typedef struct packed {
      logic [1:0] action;
      logic [7:0] data_byte;
      logic       is_dec;
      logic [3:0] dig;      // decimal or hex digit value
      logic       is_hex;
      logic       is_cr;
      logic       is_lf;
      logic       is_sp;
      logic       is_colon;
   } item_type;

   // key character tables, indexed by column
   function automatic logic [7:0] te_char(input logic [4:0] i);
      unique case (i)
         5'd0: te_char = "T";  5'd1: te_char = "r";  5'd2: te_char = "a";
         5'd3: te_char = "n";  5'd4: te_char = "s";  5'd5: te_char = "f";
         5'd6: te_char = "e";  5'd7: te_char = "r";  5'd8: te_char = "-";
         5'd9: te_char = "E";  5'd10: te_char = "n"; 5'd11: te_char = "c";
         5'd12: te_char = "o"; 5'd13: te_char = "d"; 5'd14: te_char = "i";
         5'd15: te_char = "n"; 5'd16: te_char = "g";
         default: te_char = 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] cl_char(input logic [4:0] i);
      unique case (i)
         5'd0: cl_char = "C";  5'd1: cl_char = "o";  5'd2: cl_char = "n";
         5'd3: cl_char = "t";  5'd4: cl_char = "e";  5'd5: cl_char = "n";
         5'd6: cl_char = "t";  5'd7: cl_char = "-";  5'd8: cl_char = "L";
         5'd9: cl_char = "e";  5'd10: cl_char = "n"; 5'd11: cl_char = "g";
         5'd12: cl_char = "t"; 5'd13: cl_char = "h";
         default: cl_char = 8'h00;
      endcase
   endfunction

   // "chunked" letters by scan state 2..7 (index s-1)
   function automatic logic [7:0] ch_char(input logic [3:0] s);
      unique case (s)
         4'd2: ch_char = "h"; 4'd3: ch_char = "u"; 4'd4: ch_char = "n";
         4'd5: ch_char = "k"; 4'd6: ch_char = "e"; 4'd7: ch_char = "d";
         default: ch_char = 8'h00;
      endcase
   endfunction

endpackage

### sv/hrbd_front.sv
// front part: accepts input beats and classifies the byte
// depends on hrbd_pkg
module hrbd_front import hrbd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [1:0] req_tuser,
   input  logic [7:0] req_tdata,
   output logic       q_valid,
   input  logic       q_ready,
   output item_type   q_item
);
   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic [7:0] b;

   assign req_tready = !valid_ff || q_ready;
   assign b = req_tdata;

   always_comb begin
      item_in = item_ff;
      valid_in = valid_ff;
      if (req_tready) begin
         valid_in = req_tvalid;
         item_in.action = req_tuser;
         item_in.data_byte = b;
         item_in.is_dec = b >= "0" && b <= "9";
         item_in.is_cr = b == 8'h0d;
         item_in.is_lf = b == 8'h0a;
         item_in.is_sp = b == " ";
         item_in.is_colon = b == ":";
         item_in.is_hex = 1'b1;
         if (b >= "0" && b <= "9") item_in.dig = 4'(b - "0");
         else if (b >= "a" && b <= "f") item_in.dig = 4'(b - "a" + 8'd10);
         else if (b >= "A" && b <= "F") item_in.dig = 4'(b - "A" + 8'd10);
         else begin
            item_in.dig = 4'd0;
            item_in.is_hex = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
      item_ff <= item_in;
   end

   assign q_valid = valid_ff;
   assign q_item = item_ff;
endmodule

### sv/hrbd_queue.sv
// two-entry queue between front and back parts
// depends on hrbd_pkg
module hrbd_queue import hrbd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  item_type in_item,
   output logic     out_valid,
   input  logic     out_ready,
   output item_type out_item
);
   item_type mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   assign in_ready = cnt_ff != 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;
   assign out_item = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= !wp_ff;
         if (pop) rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
      if (push) mem_ff[wp_ff] <= in_item;
   end
endmodule

### sv/hrbd_back.sv
// back part: header parser, body framer, timeout, and output register
// depends on hrbd_pkg
module hrbd_back import hrbd_pkg::*; #(
   parameter int LENGTH_WIDTH = 32,
   parameter int TICK_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [31:0] timeout_ticks,
   input  logic        q_valid,
   output logic        q_ready,
   input  item_type    q_item,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata
);
   localparam logic [LENGTH_WIDTH-1:0] LEN_MAX = '1;
   localparam logic [TICK_WIDTH-1:0] TICK_MAX = '1;
   localparam int PW = LENGTH_WIDTH + 4;

   logic [2:0]  phase_ff, phase_in;
   logic [2:0]  err_ff, err_in;
   logic [9:0]  status_ff, status_in;
   logic        chunked_ff, chunked_in;
   logic [LENGTH_WIDTH-1:0] dlen_ff, dlen_in, left_ff, left_in, num_ff, num_in;
   logic [1:0]  term_ff, term_in, tok_ff, tok_in, keys_ff, keys_in;
   logic [4:0]  col_ff, col_in;
   logic [3:0]  scan_ff, scan_in;
   logic [TICK_WIDTH-1:0] tick_ff, tick_in;
   logic        ovalid_ff, ovalid_in;
   logic [63:0] odata_ff, odata_in;

   logic        take, active, valid, hdr_end, lf;
   logic [7:0]  b, body;
   logic [PW-1:0] dec_acc, hex_acc;
   logic [13:0] st_acc;
   logic [1:0]  f;
   logic [2:0]  st_err;
   logic [63:0] tick_w;

   assign q_ready = !ovalid_ff || rsp_tready;
   assign take = q_valid && q_ready;
   assign b = q_item.data_byte;
   assign lf = q_item.is_lf;
   assign active = phase_ff >= PH_HEADER && phase_ff <= PH_CCRLF;
   // saturating accumulators, wide by four bits for overflow detection
   assign dec_acc = {4'd0, num_ff} * PW'(10) + PW'(q_item.dig);
   assign hex_acc = {num_ff, q_item.dig};
   assign st_acc = 14'(status_ff) * 14'd10 + 14'(q_item.dig);
   assign tick_w = 64'(tick_ff) + 64'(tick_ff != TICK_MAX);

   always_comb begin
      phase_in = phase_ff; err_in = err_ff; status_in = status_ff;
      chunked_in = chunked_ff; dlen_in = dlen_ff; left_in = left_ff;
      num_in = num_ff; term_in = term_ff; tok_in = tok_ff; keys_in = keys_ff;
      col_in = col_ff; scan_in = scan_ff; tick_in = tick_ff;
      valid = 1'b0; body = 8'd0; hdr_end = 1'b0; f = 2'd0; st_err = ERR_NONE;
      unique case (q_item.action)
         ACT_START: begin
            phase_in = PH_HEADER; err_in = ERR_NONE; status_in = '0;
            chunked_in = 1'b0; dlen_in = '0; left_in = '0; num_in = '0;
            term_in = '0; tok_in = '0; keys_in = 2'b11; col_in = '0;
            scan_in = '0; tick_in = '0;
         end
         ACT_DISC: if (active && err_ff == ERR_NONE) err_in = ERR_SOCKET;
         ACT_TICK: if (active && err_ff == ERR_NONE) begin
            tick_in = tick_w[TICK_WIDTH-1:0];
            if (64'(tick_in) >= 64'(timeout_ticks)) err_in = ERR_TIMEOUT;
         end
         default: if (err_ff == ERR_NONE) begin
            unique case (phase_ff)
               PH_HEADER: begin
                  // terminator tracking
                  if (q_item.is_cr) term_in = (term_ff == 2'd2) ? 2'd3 : 2'd1;
                  else if (lf) begin
                     hdr_end = term_ff == 2'd3;
                     term_in = (term_ff == 2'd1) ? 2'd2 : 2'd0;
                  end else term_in = 2'd0;
                  // status token of the first line
                  if (tok_ff != 2'd3) begin
                     if (lf) tok_in = 2'd3;
                     else if (tok_ff == 2'd0) begin
                        if (q_item.is_sp) tok_in = 2'd1;
                     end else if (tok_ff == 2'd1) begin
                        if (q_item.is_dec)
                           status_in = (st_acc > 14'd999) ? 10'd999 : st_acc[9:0];
                        else tok_in = 2'd2;
                     end
                  end
                  // key and value matching
                  if (lf) begin
                     if (keys_ff[0] && scan_ff == 4'd8) chunked_in = 1'b1;
                     if (keys_ff[1] && (scan_ff == 4'd1 || scan_ff == 4'd9 ||
                                        scan_ff == 4'd10))
                        dlen_in = num_ff;
                     col_in = '0; keys_in = 2'b11; scan_in = '0; num_in = '0;
                  end else if (scan_ff == 4'd0) begin
                     if (q_item.is_colon) begin
                        f[0] = keys_ff[0] && col_ff == TE_LEN;
                        f[1] = keys_ff[1] && col_ff == CL_LEN;
                        keys_in = f;
                        scan_in = (f != 2'd0) ? 4'd1 : 4'd15;
                     end else begin
                        if (col_ff >= TE_LEN || te_char(col_ff) != b) keys_in[0] = 1'b0;
                        if (col_ff >= CL_LEN || cl_char(col_ff) != b) keys_in[1] = 1'b0;
                        if (col_ff < 5'd31) col_in = col_ff + 5'd1;
                     end
                  end else if (scan_ff != 4'd15) begin
                     if (keys_ff[0]) begin
                        if (scan_ff == 4'd1)
                           scan_in = q_item.is_sp ? 4'd1 : (b == "c" ? 4'd2 : 4'd15);
                        else if (scan_ff >= 4'd2 && scan_ff <= 4'd7)
                           scan_in = (b == ch_char(scan_ff)) ? scan_ff + 4'd1 : 4'd15;
                        else if (scan_ff == 4'd8)
                           scan_in = (q_item.is_sp || q_item.is_cr) ? 4'd8 : 4'd15;
                        else scan_in = 4'd15;
                     end else if (keys_ff[1]) begin
                        if (scan_ff == 4'd1) begin
                           if (q_item.is_dec) begin
                              num_in = LENGTH_WIDTH'(q_item.dig); scan_in = 4'd9;
                           end else if (!q_item.is_sp) scan_in = 4'd10;
                        end else if (scan_ff == 4'd9) begin
                           if (q_item.is_dec)
                              num_in = (dec_acc[PW-1 -: 4] != 4'd0) ? LEN_MAX
                                       : dec_acc[LENGTH_WIDTH-1:0];
                           else scan_in = 4'd10;
                        end
                     end else scan_in = 4'd15;
                  end
                  if (hdr_end) begin
                     if (status_in >= 10'd400 && status_in < 10'd500) st_err = ERR_CLIENT;
                     else if (status_in >= 10'd500 && status_in < 10'd600)
                        st_err = ERR_SERVER;
                     err_in = st_err;
                     scan_in = '0; num_in = '0;
                     if (chunked_in) phase_in = PH_CSIZE;
                     else if (dlen_in != '0) begin
                        left_in = dlen_in; phase_in = PH_LBODY;
                     end else phase_in = PH_DONE;
                  end
               end
               PH_LBODY, PH_CDATA: begin
                  valid = 1'b1; body = b;
                  left_in = left_ff - 1'b1;
                  if (left_in == '0) begin
                     if (phase_ff == PH_LBODY) phase_in = PH_DONE;
                     else begin
                        phase_in = PH_CCRLF; term_in = '0;
                     end
                  end
               end
               PH_CSIZE: begin
                  if (lf) begin
                     if (num_ff == '0) phase_in = PH_DONE;
                     else begin
                        left_in = num_ff; phase_in = PH_CDATA;
                     end
                     num_in = '0; scan_in = '0;
                  end else if (scan_ff == 4'd0) begin
                     if (q_item.is_hex)
                        num_in = (hex_acc[PW-1 -: 4] != 4'd0) ? LEN_MAX
                                 : hex_acc[LENGTH_WIDTH-1:0];
                     else scan_in = 4'd1;
                  end
               end
               PH_CCRLF: begin
                  if (term_ff == 2'd1) begin
                     phase_in = PH_CSIZE; term_in = '0; num_in = '0; scan_in = '0;
                  end else term_in = 2'd1;
               end
               default: ;
            endcase
         end
      endcase
      ovalid_in = ovalid_ff && !rsp_tready;
      odata_in = odata_ff;
      if (take) begin
         ovalid_in = 1'b1;
         odata_in = {5'd0, 32'(dlen_in), chunked_in,
                     phase_in == PH_DONE && err_in == ERR_NONE,
                     status_in, err_in, phase_in, body, valid};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE; err_ff <= ERR_NONE; status_ff <= '0;
         chunked_ff <= 1'b0; dlen_ff <= '0; left_ff <= '0; num_ff <= '0;
         term_ff <= '0; tok_ff <= '0; keys_ff <= 2'b11; col_ff <= '0;
         scan_ff <= '0; tick_ff <= '0; ovalid_ff <= 1'b0;
      end else begin
         ovalid_ff <= ovalid_in;
         if (take) begin
            phase_ff <= phase_in; err_ff <= err_in; status_ff <= status_in;
            chunked_ff <= chunked_in; dlen_ff <= dlen_in; left_ff <= left_in;
            num_ff <= num_in; term_ff <= term_in; tok_ff <= tok_in;
            keys_ff <= keys_in; col_ff <= col_in; scan_ff <= scan_in;
            tick_ff <= tick_in;
         end
      end
      odata_ff <= odata_in;
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata = odata_ff;
endmodule

### sv/http_response_body_deframer.sv
// top level of the http response body deframer
// depends on hrbd_pkg, hrbd_front, hrbd_queue, hrbd_back and the assert header
//
// takes an http/1.1 response as a stream of beats (start, byte, disconnect,
// tick) and returns one result beat per input beat: the body byte when there
// is one plus phase, error, status code, chunked flag and content length.
// the header is parsed to the first crlfcrlf, the body is framed by content
// length or by hex chunk sizes. one beat per cycle is sustained while
// rsp_tready stays high; a request beat goes through the front register, a
// queue entry and the back state update into the output register. the
// timeout register is written through csr_wen/csr_wdata; the user must
// write it only while the block is idle, which the block does not enforce.
`include "http_response_body_deframer_assert.svh"
module http_response_body_deframer import hrbd_pkg::*; #(
   parameter int LENGTH_WIDTH = 32,
   parameter int TICK_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   input  logic [1:0]  req_tuser,   // action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // body_valid, body_byte, phase_now, error_code, status_code, done_res,
   // chunked_mode, length_seen, zero fill
   output logic [63:0] rsp_tdata,
   input  logic        csr_wen,
   input  logic [31:0] csr_wdata
);
   logic [31:0] timeout_ff;
   logic        f_valid, f_ready, b_valid, b_ready;
   item_type    f_item, b_item;
   logic [2:0]  rsp_ph, rsp_err;
   logic        rsp_body_ph;

   // timeout register
   always_ff @(posedge clock) begin
      if (reset) timeout_ff <= 32'd250;
      else if (csr_wen) timeout_ff <= csr_wdata;
   end

   hrbd_front u_front (
      .clock, .reset, .req_tvalid, .req_tready, .req_tuser, .req_tdata,
      .q_valid(f_valid), .q_ready(f_ready), .q_item(f_item)
   );

   hrbd_queue u_queue (
      .clock, .reset, .in_valid(f_valid), .in_ready(f_ready), .in_item(f_item),
      .out_valid(b_valid), .out_ready(b_ready), .out_item(b_item)
   );

   hrbd_back #(.LENGTH_WIDTH(LENGTH_WIDTH), .TICK_WIDTH(TICK_WIDTH)) u_back (
      .clock, .reset, .timeout_ticks(timeout_ff),
      .q_valid(b_valid), .q_ready(b_ready), .q_item(b_item),
      .rsp_tvalid, .rsp_tready, .rsp_tdata
   );

   // result fields seen by the checks below
   assign rsp_ph = rsp_tdata[11:9];
   assign rsp_err = rsp_tdata[14:12];
   assign rsp_body_ph = rsp_ph == PH_LBODY || rsp_ph == PH_CDATA || rsp_ph == PH_DONE ||
                        rsp_ph == PH_CCRLF;

   // a body byte only appears in a body phase with no error
   `HRBD_ASSERT_IMP(a_body_phase, clock, reset, rsp_tvalid && rsp_tdata[0], rsp_body_ph && rsp_err == ERR_NONE)
   // done flag agrees with phase and error
   `HRBD_ASSERT_IMP(a_done, clock, reset, rsp_tvalid && rsp_tdata[25], rsp_ph == PH_DONE && rsp_err == ERR_NONE)
   // a stalled result holds
   `HRBD_ASSERT_NEXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
endmodule
